// ----- src/ddjm_pkg.sv -----
package ddjm_pkg;

  // Field and datapath widths
  localparam int AXIS_W   = 16;
  localparam int SPEED_W  = 10;
  localparam int PIVOT_W  = 7;
  localparam int DRIVE_W  = 11;
  localparam int STEER_W  = 9;   // steer -126..128, throttle -128..126, premix base -1..127
  localparam int PIV_W    = 10;  // pivot term, +/- steer
  localparam int WEIGHT_W = 17;  // pivot weight, Q1.16, 0..65536
  localparam int MUL_A_W  = 20;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int MIX_W    = 10;
  localparam int MAG_W    = 19;  // |max_speed * (2*mix + 1)|
  localparam int CFG_A_W  = 2;
  localparam int AXIS_IN_W  = 2 * AXIS_W;
  localparam int DRIVE_PAD  = 24 - 2 * DRIVE_W;

  localparam logic [2:0]          DECIM_PERIOD    = 3'd7;
  localparam logic [STEER_W-1:0]  PREMIX_FULL     = 9'sd127;
  localparam logic [SPEED_W-1:0]  MAX_SPEED_RST   = 10'd250;
  localparam logic [PIVOT_W-1:0]  PIVOT_LIMIT_RST = 7'd32;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE      = 17'h10000;
  localparam logic [MUL_B_W-1:0]  RECIP_255       = 18'd32897;  // ceil(2^23 / 255)
  localparam int                  RECIP_SHIFT     = 23;
  localparam int                  MIX_SHIFT       = 23;
  localparam logic [PROD_W-1:0]   MIX_ROUND       = 38'h00007FFFFF;

  localparam logic [CFG_A_W-1:0] CFG_MAX_SPEED   = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_PIVOT_LIMIT = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MB,
    ST_MT1,
    ST_MT2,
    ST_MIX,
    ST_MSP,
    ST_MQ,
    ST_FIX,
    ST_OUT
  } state_e;

endpackage

// ----- src/differential_drive_joystick_mixer_unit.sv -----
// Differential-drive joystick mixer.
//
// Input stream (s_axis_*): one beat per joystick sample, steering and throttle
// axes in Q1.15. Output stream (m_axis_*): one beat with the left and right
// motor commands, each in -max_speed..+max_speed. Every seventh sample is
// dropped by the decimation counter and gives no output beat.
// Configuration: cfg_we_i writes register cfg_addr_i (0 max_speed, 1 pivot
// limit) with cfg_wdata_i; other indexes are ignored. Write only while idle.
//
// Timing: one shared 20x18 multiplier runs a seven-step sequence per motor.
// With pivot blending the serial pivot-weight divider runs before the motor
// sequence. A dropped sample leaves the sequencer idle. s_axis_tready is high
// only while the sequencer is idle, so one sample is in flight at a time and
// the next one is not taken until the last one has been passed on to the
// output register.
// The output beat sits in its own register: a stalled receiver does not stop
// the next sample from being accepted and processed; the sequencer holds its
// finished result until the output register frees up.
// Reset clears the decimation counter, the output valid and the sequencer,
// and restores max_speed to 250 and pivot limit to 32.
module differential_drive_joystick_mixer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ddjm_pkg::AXIS_IN_W-1:0] s_axis_tdata,   // axis_x[15:0], axis_y[31:16]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,   // left_drive[10:0], right_drive[21:11]
  input  logic                          cfg_we_i,
  input  logic [ddjm_pkg::CFG_A_W-1:0]  cfg_addr_i,
  input  logic [ddjm_pkg::SPEED_W-1:0]  cfg_wdata_i
);
  import ddjm_pkg::*;

  // Map a Q1.15 axis term to an integer, truncating toward zero.
  function automatic logic signed [STEER_W-1:0] axis_map(input logic signed [25:0] num);
    logic signed [25:0] adj;
    adj = num[25] ? num + 26'sd65535 : num;
    return STEER_W'(adj >>> 16);
  endfunction

  state_e state_q, state_d;

  logic [2:0]           dec_cnt_q, dec_cnt_d;
  logic [SPEED_W-1:0]   max_speed_q;
  logic [PIVOT_W-1:0]   pivot_limit_q;

  logic signed [STEER_W-1:0] x_q, y_q, base_l_q, base_r_q;
  logic [WEIGHT_W-1:0]       s_q;
  logic signed [PROD_W-1:0]  prod_q, acc_q;
  logic signed [MIX_W-1:0]   mix_q;
  logic                      neg_q, side_q;
  logic [DRIVE_W-1:0]        left_q, right_q;
  logic                      out_valid_q;
  logic [DRIVE_W-1:0]        out_left_q, out_right_q;

  logic                      in_beat, out_free, keep_sample;
  logic [2:0]                dec_inc;
  logic signed [25:0]        ax_ext, ay_ext;
  logic signed [STEER_W-1:0] x_new, y_new;

  logic [STEER_W-1:0]        y_abs;
  logic                      piv_on;
  logic [PIVOT_W-1:0]        div_num;
  logic                      div_start, div_done;
  logic [WEIGHT_W-1:0]       div_quot;
  logic signed [STEER_W-1:0] base_a, base_b;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [STEER_W-1:0] base_sel;
  logic signed [PIV_W-1:0]   x_ext, pivot;
  logic [WEIGHT_W-1:0]       w_inv;
  logic signed [DRIVE_W-1:0] mix_odd;
  logic [PROD_W-1:0]         prod_abs;

  logic signed [PROD_W-1:0]  mix_sum, mix_adj;
  logic [DRIVE_W-1:0]        q_est, q_fix, q_clamp, drv;
  logic [MAG_W-1:0]          q255;
  logic signed [MAG_W+1:0]   rem_chk;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // decimation: count 0..6, drop the sample that would bring it to 7
  assign dec_inc     = dec_cnt_q + 3'd1;
  assign keep_sample = dec_inc != DECIM_PERIOD;

  always_comb begin
    dec_cnt_d = dec_cnt_q;
    if (in_beat) begin
      dec_cnt_d = keep_sample ? dec_inc : '0;
    end
  end

  // steer = trunc((32768 - 255*ax) / 65536), throttle = trunc((255*ay - 32768) / 65536)
  assign ax_ext = {{10{s_axis_tdata[AXIS_W-1]}}, s_axis_tdata[AXIS_W-1:0]};
  assign ay_ext = {{10{s_axis_tdata[AXIS_IN_W-1]}}, s_axis_tdata[AXIS_IN_W-1:AXIS_W]};
  assign x_new  = axis_map(26'sd32768 - ((ax_ext <<< 8) - ax_ext));
  assign y_new  = axis_map(((ay_ext <<< 8) - ay_ext) - 26'sd32768);

  // pivot weight setup and premix bases
  assign y_abs   = y_q[STEER_W-1] ? STEER_W'(-y_q) : y_q;
  assign piv_on  = (pivot_limit_q != '0) && (y_abs <= {2'b00, pivot_limit_q});
  assign div_num = pivot_limit_q - y_abs[PIVOT_W-1:0];
  assign base_a  = x_q[STEER_W-1] ? PREMIX_FULL + x_q : PREMIX_FULL;
  assign base_b  = x_q[STEER_W-1] ? PREMIX_FULL : PREMIX_FULL - x_q;

  ddjm_piv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (pivot_limit_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_beat && keep_sample) state_d = ST_PREP;
      ST_PREP: state_d = piv_on ? ST_DIV : ST_MB;
      ST_DIV:  if (div_done) state_d = ST_MB;
      ST_MB:   state_d = ST_MT1;
      ST_MT1:  state_d = ST_MT2;
      ST_MT2:  state_d = ST_MIX;
      ST_MIX:  state_d = ST_MSP;
      ST_MSP:  state_d = ST_MQ;
      ST_MQ:   state_d = ST_FIX;
      ST_FIX:  state_d = side_q ? ST_OUT : ST_MB;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign base_sel = side_q ? base_r_q : base_l_q;
  assign x_ext    = {{(PIV_W-STEER_W){x_q[STEER_W-1]}}, x_q};
  assign pivot    = side_q ? -x_ext : x_ext;
  assign w_inv    = WEIGHT_ONE - s_q;
  assign mix_odd  = {mix_q, 1'b1};
  assign prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : prod_q;

  // control outputs and shared multiplier operands
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_PREP: div_start = piv_on;
      ST_MB: begin
        // premix product base * throttle
        mul_a = {{(MUL_A_W-STEER_W){base_sel[STEER_W-1]}}, base_sel};
        mul_b = {{(MUL_B_W-STEER_W){y_q[STEER_W-1]}}, y_q};
      end
      ST_MT1: begin
        mul_a = {{(MUL_A_W-WEIGHT_W){1'b0}}, w_inv};
        mul_b = prod_q[MUL_B_W-1:0];
      end
      ST_MT2: begin
        mul_a = {{(MUL_A_W-WEIGHT_W){1'b0}}, s_q};
        mul_b = {{(MUL_B_W-PIV_W){pivot[PIV_W-1]}}, pivot};
      end
      ST_MSP: begin
        mul_a = {{(MUL_A_W-SPEED_W){1'b0}}, max_speed_q};
        mul_b = {{(MUL_B_W-DRIVE_W){mix_odd[DRIVE_W-1]}}, mix_odd};
      end
      ST_MQ: begin
        // divide by 255 through the reciprocal, corrected in ST_FIX
        mul_a = {{(MUL_A_W-MAG_W){1'b0}}, prod_abs[MAG_W-1:0]};
        mul_b = RECIP_255;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // mix = trunc((t1 + 128*s*pivot) / 2^23)
  assign mix_sum = acc_q + (prod_q <<< 7);
  assign mix_adj = mix_sum[PROD_W-1] ? mix_sum + MIX_ROUND : mix_sum;

  // estimate is floor(mag/255) or one above it
  assign q_est   = prod_q[RECIP_SHIFT+DRIVE_W-1:RECIP_SHIFT];
  assign q255    = {q_est, 8'b0} - {{(MAG_W-DRIVE_W){1'b0}}, q_est};
  assign rem_chk = $signed({2'b00, acc_q[MAG_W-1:0]}) - $signed({2'b00, q255});
  assign q_fix   = rem_chk[MAG_W+1] ? q_est - 11'd1 : q_est;
  assign q_clamp = (q_fix > {1'b0, max_speed_q}) ? {1'b0, max_speed_q} : q_fix;
  assign drv     = neg_q ? DRIVE_W'(-q_clamp) : q_clamp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      dec_cnt_q     <= '0;
      max_speed_q   <= MAX_SPEED_RST;
      pivot_limit_q <= PIVOT_LIMIT_RST;
      out_valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      dec_cnt_q <= dec_cnt_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_MAX_SPEED:   max_speed_q   <= cfg_wdata_i;
          CFG_PIVOT_LIMIT: pivot_limit_q <= cfg_wdata_i[PIVOT_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath, advanced by the sequencer
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          x_q <= x_new;
          y_q <= y_new;
        end
      end
      ST_PREP: begin
        side_q   <= 1'b0;
        base_l_q <= y_q[STEER_W-1] ? base_b : base_a;
        base_r_q <= y_q[STEER_W-1] ? base_a : base_b;
        if (!piv_on) s_q <= '0;
      end
      ST_DIV: begin
        if (div_done) s_q <= div_quot;
      end
      ST_MB, ST_MT1, ST_MSP: prod_q <= mul_p;
      ST_MT2: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      ST_MIX: mix_q <= MIX_W'(mix_adj >>> MIX_SHIFT);
      ST_MQ: begin
        acc_q  <= prod_abs;
        neg_q  <= prod_q[PROD_W-1];
        prod_q <= mul_p;
      end
      ST_FIX: begin
        if (side_q) begin
          right_q <= drv;
        end else begin
          left_q <= drv;
          side_q <= 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_left_q  <= left_q;
          out_right_q <= right_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{DRIVE_PAD{1'b0}}, out_right_q, out_left_q};

endmodule

// ----- src/ddjm_piv_div.sv -----
// Restoring divider for the pivot weight: quot = floor(num * 2^16 / den), num <= den.
// One quotient bit per cycle, WEIGHT_W quotient bits per division.
module ddjm_piv_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ddjm_pkg::PIVOT_W-1:0]     num_i,
  input  logic [ddjm_pkg::PIVOT_W-1:0]     den_i,
  output logic                             done_o,
  output logic [ddjm_pkg::WEIGHT_W-1:0]    quot_o
);
  import ddjm_pkg::*;

  logic [PIVOT_W:0]    rem_q, rem_d;
  logic [WEIGHT_W-1:0] quot_q, quot_d;
  logic [4:0]          cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic                ge;
  logic [PIVOT_W:0]    diff;

  always_comb begin
    ge     = rem_q >= {1'b0, den_i};
    diff   = ge ? rem_q - {1'b0, den_i} : rem_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      quot_d = '0;
      cnt_d  = 5'(WEIGHT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // remainder stays below den, so one shift fits
      rem_d  = {diff[PIVOT_W-1:0], 1'b0};
      quot_d = {quot_q[WEIGHT_W-2:0], ge};
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- src/ddjm_checker.sv -----
module ddjm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // clamping keeps both drives inside -1023..1023
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[10:0] != 11'h400 && m_axis_tdata[21:11] != 11'h400)
    else $error("drive command outside clamp range");

  // a result never appears right after a sample is taken
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("output beat too soon after input beat");

  // an edge inside reset leaves the output valid low
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind differential_drive_joystick_mixer_unit ddjm_checker u_ddjm_checker (.*);

// ----- test/differential_drive_joystick_mixer_unit_tb.sv -----
`timescale 1ns / 1ps

module differential_drive_joystick_mixer_unit_tb;
  import ddjm_pkg::*;

  // Register index that maps to no register; writes to it must be dropped.
  localparam logic [CFG_A_W-1:0] CFG_UNMAPPED = 2'd3;
  // Covers the slowest sample (pivot divider path) with margin.
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int SAMPLES_PER_PHASE = 140;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DRIVE_W-1:0] left_drive;
    logic [DRIVE_W-1:0] right_drive;
  } drive_pair_t;

  // Mixer model plus the queue of motor commands still owed by the block.
  class drive_scoreboard;
    bit [2:0]           decim_cnt;
    bit [SPEED_W-1:0]   max_speed;
    bit [PIVOT_W-1:0]   pivot_limit;
    drive_pair_t        due_q[$];
    int unsigned        errors;
    int unsigned        samples;
    int unsigned        dropped;
    int unsigned        beats;
    int unsigned        pivot_hits;
    int unsigned        clamp_hits;

    function new();
      decim_cnt   = '0;
      max_speed   = MAX_SPEED_RST;
      pivot_limit = PIVOT_LIMIT_RST;
    endfunction

    function void set_register(logic [CFG_A_W-1:0] addr, logic [SPEED_W-1:0] value);
      case (addr)
        CFG_MAX_SPEED:   max_speed = value;
        CFG_PIVOT_LIMIT: pivot_limit = value[PIVOT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_failure(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("[%0t] %s", $realtime, msg);
    endfunction

    // Blend the throttle-scaled premix with the in-place pivot term (Q.32).
    function longint mix_motor(longint base, longint thr, longint weight, longint pivot);
      longint premix, acc;
      premix = base * thr * 512;
      acc = (65536 - weight) * premix + weight * (pivot * 65536);
      return acc / 64'sd4294967296;
    endfunction

    // Map -128..127 onto -max_speed..+max_speed, clamp the full-steer overshoot.
    function logic [DRIVE_W-1:0] scale_drive(longint mix);
      longint sp, v;
      sp = longint'(max_speed);
      v = sp * (2 * mix + 1) / 255;
      if (v > sp) begin
        v = sp;
        clamp_hits++;
      end
      if (v < -sp) begin
        v = -sp;
        clamp_hits++;
      end
      return v[DRIVE_W-1:0];
    endfunction

    function void note_sample(logic [AXIS_W-1:0] ax, logic [AXIS_W-1:0] ay);
      longint steer, thr, mag, lim, weight, base_l, base_r;
      drive_pair_t due;
      samples++;
      // Every seventh sample is swallowed by the decimation counter.
      if (decim_cnt >= DECIM_PERIOD - 3'd1) begin
        decim_cnt = '0;
        dropped++;
        return;
      end
      decim_cnt++;
      steer = (32768 - 255 * longint'($signed(ax))) / 65536;
      thr   = (255 * longint'($signed(ay)) - 32768) / 65536;
      // Forward premix; reverse swaps the motor roles.
      if ((thr >= 0) == (steer >= 0)) begin
        base_l = longint'(PREMIX_FULL);
        base_r = longint'(PREMIX_FULL) + ((thr >= 0) ? -steer : steer);
      end else begin
        base_l = longint'(PREMIX_FULL) + ((thr >= 0) ? steer : -steer);
        base_r = longint'(PREMIX_FULL);
      end
      mag = (thr < 0) ? -thr : thr;
      lim = longint'(pivot_limit);
      if (lim == 0 || mag > lim) weight = 0;
      else weight = ((lim - mag) * 65536) / lim;
      if (weight != 0) pivot_hits++;
      due.left_drive  = scale_drive(mix_motor(base_l, thr, weight, steer));
      due.right_drive = scale_drive(mix_motor(base_r, thr, weight, -steer));
      due_q.push_back(due);
    endfunction

    function void check_drive(logic [DRIVE_W-1:0] left_v, logic [DRIVE_W-1:0] right_v);
      drive_pair_t due;
      beats++;
      if (due_q.size() == 0) begin
        note_failure($sformatf("unexpected drive beat: left %0d right %0d",
                               $signed(left_v), $signed(right_v)));
        return;
      end
      due = due_q.pop_front();
      if (due.left_drive !== left_v || due.right_drive !== right_v)
        note_failure($sformatf("drive mismatch: expected left %0d right %0d, got left %0d right %0d",
                               $signed(due.left_drive), $signed(due.right_drive),
                               $signed(left_v), $signed(right_v)));
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  // Every input holds a known value from time zero.
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [AXIS_IN_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_A_W-1:0]    cfg_addr_i = '0;
  logic [SPEED_W-1:0]    cfg_wdata_i = '0;

  // Suppresses random gaps and stalls on both sides while set.
  bit                    steady = 1'b0;
  int unsigned           settings_seen = 1;
  drive_scoreboard       sb = new();

  differential_drive_joystick_mixer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // axis_x[15:0], axis_y[31:16]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // left_drive[10:0], right_drive[21:11]
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Receiver: stall about a quarter of the cycles unless the steady window is on.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 25);
    end
  end

  // Check every output beat against the oldest owed motor command.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_drive(m_axis_tdata[DRIVE_W-1:0], m_axis_tdata[2*DRIVE_W-1:DRIVE_W]);
  end

  // Axis value whose mapped throttle is exactly t (clamped to -128..126).
  function automatic logic [AXIS_W-1:0] throttle_axis(int t);
    int num;
    if (t > 126) t = 126;
    if (t < -128) t = -128;
    num = t * 65536 + 32768;
    // Round up for positive targets, down for negative ones.
    if (t >= 0) return AXIS_W'((num + 254) / 255);
    return AXIS_W'((num - 254) / 255);
  endfunction

  function automatic logic [AXIS_W-1:0] pick_axis();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return AXIS_W'($urandom_range(0, 511)) - 16'd256;
      default: return AXIS_W'($urandom);
    endcase
  endfunction

  // Throttle aimed at the pivot blending region about half the time.
  function automatic logic [AXIS_W-1:0] pick_throttle(int lim);
    int t;
    if ($urandom_range(1)) return pick_axis();
    t = $urandom_range(0, lim + 2);
    return throttle_axis($urandom_range(1) ? t : -t);
  endfunction

  // Present one sample, with random gaps ahead of it; note it once accepted.
  task automatic send_sample(input logic [AXIS_W-1:0] ax, input logic [AXIS_W-1:0] ay);
    while (!steady && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ay, ax};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(ax, ay);
  endtask

  // Drop valid, drain every owed beat, then let a dropped sample finish.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_A_W-1:0] addr,
                                input logic [SPEED_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_register(addr, value);
  endtask

  initial begin
    logic [SPEED_W-1:0] speed_val, pivot_val;
    int pl;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, axis extremes, full steer with no throttle
    // (drive overshoot), and throttle right at the pivot limit boundary.
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h7FFF, 16'h0000);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h0000, 16'h7FFF);
    send_sample(16'h0000, 16'h8000);
    send_sample(16'h4000, throttle_axis(32));
    send_sample(16'hC000, throttle_axis(33));
    send_sample(16'h8000, throttle_axis(-32));
    send_sample(16'h7FFF, throttle_axis(-33));
    send_sample(16'h2000, throttle_axis(31));
    send_sample(16'hE000, throttle_axis(1));
    settle();

    // Zero pivot limit at the largest speed: no blending anywhere.
    write_register(CFG_MAX_SPEED, 10'd1023);
    write_register(CFG_PIVOT_LIMIT, 10'd0);
    settings_seen++;
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h7FFF, 16'h0000);
    send_sample(16'h1234, throttle_axis(1));
    send_sample(16'hEDCC, throttle_axis(-1));
    settle();

    // Unmapped register index: both registers must keep their values.
    write_register(CFG_UNMAPPED, 10'd5);
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h6000, throttle_axis(-2));
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          speed_val = 10'd1023;
          pivot_val = 10'd127;
        end
        1: begin
          speed_val = 10'd0;
          pivot_val = 10'd1;
        end
        2: begin
          // Upper wdata bits beyond the pivot register are dropped.
          speed_val = 10'd1;
          pivot_val = 10'h380;
        end
        default: begin
          speed_val = SPEED_W'($urandom_range(0, 1023));
          pivot_val = SPEED_W'($urandom_range(0, 1023));
        end
      endcase
      write_register(CFG_MAX_SPEED, speed_val);
      write_register(CFG_PIVOT_LIMIT, pivot_val);
      settings_seen++;
      steady = (ph == 3);
      pl = int'(pivot_val[PIVOT_W-1:0]);
      for (int n = 0; n < SAMPLES_PER_PHASE; n++)
        send_sample(pick_axis(), pick_throttle(pl));
      settle();
      steady = 1'b0;
    end

    if (sb.pending() != 0)
      sb.note_failure($sformatf("%0d drive beats never arrived", sb.pending()));
    $display("Sent %0d joystick samples (%0d dropped by decimation) over %0d settings",
             sb.samples, sb.dropped, settings_seen);
    $display("Checked %0d drive beats: %0d with pivot blending, %0d drives clamped",
             sb.beats, sb.pivot_hits, sb.clamp_hits);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d failures", sb.errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timeout: run did not finish, %0d drive beats still owed", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
